// File: rtl/core/ordered_list_insert_engine_assert.svh
// assertion shorthands for the ordered list insert engine
// every macro samples on clk and is disabled while rst is high
`ifndef ORDERED_LIST_INSERT_ENGINE_ASSERT_SVH
`define ORDERED_LIST_INSERT_ENGINE_ASSERT_SVH

// condition holds at every edge out of reset
`define OLIE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define OLIE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define OLIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/olie_pkg.sv
`timescale 1ns / 1ps

package olie_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int TOKEN_W      = 32;
  localparam int PLACE_W      = 8;
  localparam int IDX_W        = 7;

  typedef enum logic [1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_END   = 2'd1,
    ACT_INS_AT    = 2'd2,
    ACT_DISPLAY   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_RESP,
    S_DISP_RD,
    S_DISP_OUT
  } state_t;

  typedef struct packed {
    action_t                     action;
    logic signed [TOKEN_W-1:0]   token;
    logic        [PLACE_W-1:0]   place;
  } req_t;

  typedef struct packed {
    status_t                     status;
    logic signed [TOKEN_W-1:0]   entry_value;
    logic        [IDX_W-1:0]     entry_index;
    logic                        last;
  } rsp_t;

endpackage

// File: rtl/core/olie_stream_if.sv
`timescale 1ns / 1ps

interface olie_stream_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (input clk, output valid, output payload, input ready);
  modport sink   (input clk, input valid, input payload, output ready);
endinterface

// File: rtl/core/olie_ram.sv
`timescale 1ns / 1ps

module olie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/ordered_list_insert_engine.sv
`timescale 1ns / 1ps
// channel | dir | fields                          | beats per item
// --------+-----+---------------------------------+------------------------
// req     | in  | action, token, place            | 1
// rsp     | out | status, entry_value,            | 1, or count on display
//         |     | entry_index, last               |
//
// one item at a time; req.ready is high only while the engine is idle
// insert at slot p (0-based) of a list of n: the n-p entries from slot p up
//   move up one slot, one entry per cycle through the single ram write
//   port, then the token is written to slot p
// display: one ram read for the first entry, then one entry a cycle while
//   rsp is ready; error, full and empty answers go straight to the reply
// rst clears the entry count, the fsm and the output valid flag; the entry
//   ram is not cleared, only entries below the count are ever read
// a stalled rsp holds its beat in the output register and the fsm waits

module ordered_list_insert_engine
  import olie_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  olie_stream_if.sink   req,
  olie_stream_if.source rsp
);

  // address and count widths follow the capacity
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > PLACE_W) ? CW : PLACE_W) + 1;

  // control state
  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] cur;       // slot that receives the next shifted entry
  logic [CW-1:0] pos;       // insert slot
  logic [CW-1:0] ptr;       // display walk pointer
  logic          pend;      // shifted entry in flight from the ram read port
  logic [AW-1:0] pend_addr;
  logic          out_valid;

  // payload registers
  logic signed [TOKEN_W-1:0] tok;
  status_t                   resp_status;
  rsp_t                      out_pl;

  // ram ports
  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [TOKEN_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [TOKEN_W-1:0] ram_rd_data;

  // handshake and decode
  logic          in_fire;
  logic          out_free;
  logic          bad_place;
  logic          list_full;
  logic [CW-1:0] ins_pos;
  status_t       acc_status;
  logic          shift_done;
  logic          last_ent;
  logic [CW-1:0] ptr_inc;

  // fsm outputs
  logic in_ready;
  logic load_resp;
  logic load_disp;
  logic count_inc;
  logic ptr_adv;

  assign in_fire  = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  // the insert is finished once the walk reached the slot with no shifted
  // entry still waiting to be written
  assign shift_done = (cur == pos) && !pend;
  assign ptr_inc    = ptr + CW'(1);
  assign last_ent   = (ptr_inc == count);

  // position check comes before the fullness check
  always_comb begin
    bad_place = 1'b0;
    ins_pos   = '0;
    case (req.payload.action)
      ACT_INS_FRONT: ins_pos = '0;
      ACT_INS_END:   ins_pos = count;
      ACT_INS_AT: begin
        bad_place = (req.payload.place == '0) ||
                    (CMPW'(req.payload.place) > (CMPW'(count) + CMPW'(1)));
        ins_pos   = CW'(CMPW'(req.payload.place) - CMPW'(1));
      end
      ACT_DISPLAY:   ins_pos = '0;
      default:       ins_pos = '0;
    endcase
    list_full = (count == CW'(CAPACITY));
    if (req.payload.action == ACT_DISPLAY) begin
      acc_status = ST_EMPTY;
    end else if (bad_place) begin
      acc_status = ST_BADPOS;
    end else if (list_full) begin
      acc_status = ST_FULL;
    end else begin
      acc_status = ST_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (req.payload.action == ACT_DISPLAY) begin
            state_next = (count == '0) ? S_RESP : S_DISP_RD;
          end else if (acc_status == ST_OK) begin
            state_next = S_SHIFT;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DISP_RD: begin
        state_next = S_DISP_OUT;
      end
      S_DISP_OUT: begin
        if (out_free && last_ent) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // fsm outputs and ram control
  always_comb begin
    in_ready    = 1'b0;
    load_resp   = 1'b0;
    load_disp   = 1'b0;
    count_inc   = 1'b0;
    ptr_adv     = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = pend_addr;
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = AW'(ptr);
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_SHIFT: begin
        // walk down from the tail: read slot cur-1, write it to cur next cycle
        if (pend) begin
          ram_wr_en = 1'b1;
        end else if (cur == pos) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = AW'(pos);
          ram_wr_data = tok;
          count_inc   = 1'b1;
        end
        if (cur > pos) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(cur - CW'(1));
        end
      end
      S_RESP: begin
        load_resp = out_free;
      end
      S_DISP_RD: begin
        ram_rd_en = 1'b1;
      end
      S_DISP_OUT: begin
        // prefetch the next entry as this one goes out
        load_disp = out_free;
        if (out_free && !last_ent) begin
          ptr_adv     = 1'b1;
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(ptr_inc);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (count_inc) begin
        count <= count + CW'(1);
      end
      if (state == S_SHIFT) begin
        pend <= ram_rd_en;
      end else begin
        pend <= 1'b0;
      end
      if (load_resp || load_disp) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk pointers and payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tok         <= req.payload.token;
      pos         <= ins_pos;
      cur         <= count;
      ptr         <= '0;
      resp_status <= acc_status;
    end
    if (state == S_SHIFT && ram_rd_en) begin
      cur       <= cur - CW'(1);
      pend_addr <= AW'(cur);
    end
    if (ptr_adv) begin
      ptr <= ptr_inc;
    end
    if (load_resp) begin
      out_pl.status      <= resp_status;
      out_pl.entry_value <= '0;
      out_pl.entry_index <= '0;
      out_pl.last        <= 1'b1;
    end else if (load_disp) begin
      out_pl.status      <= ST_OK;
      out_pl.entry_value <= ram_rd_data;
      out_pl.entry_index <= IDX_W'(ptr_inc);
      out_pl.last        <= last_ent;
    end
  end

  assign req.ready   = in_ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_pl;

  olie_ram #(
    .WIDTH (TOKEN_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  `include "ordered_list_insert_engine_assert.svh"

  `OLIE_ASSERT_ALWAYS(a_count_cap, count <= CW'(CAPACITY), "entry count above capacity")
  `OLIE_ASSERT_IMPLY(a_walk_bound, state == S_SHIFT, cur >= pos, "shift walk passed the slot")
  `OLIE_ASSERT_IMPLY(a_pend_slot, pend, (CW'(pend_addr) > pos) && (CW'(pend_addr) <= count), "shifted entry outside list")
  `OLIE_ASSERT_NEXT(a_one_grow, count_inc, state == S_RESP, "insert did not answer")

endmodule
